FILE: rtl/wsd_pkg.sv
// ============================================================================
// wsd_pkg: shared types and constants for the WebSocket deframer
// Result kinds, frame opcodes, queue sizing and the word carried from parser
// to output stage.
// ============================================================================
package wsd_pkg;

    // Default width of the saturating message length counter
    localparam int MSG_LEN_BITS_DEF = 32;

    // Depth of the result queue between parser and output stage
    localparam int Q_DEPTH_DEF = 2;

    // Result kinds
    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_BIN   = 2'd1;
    localparam logic [1:0] KIND_PING  = 2'd2;
    localparam logic [1:0] KIND_CLOSE = 2'd3;

    // Frame opcodes
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    // 7-bit length codes that announce an extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // One classified result: raw byte plus the mask byte to apply
    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] mask;
        logic       has_byte;
        logic [1:0] kind;
        logic       eom;
    } t_cmd;

endpackage

FILE: rtl/wsd_front.sv
// ============================================================================
// wsd_front: frame header parser and byte classifier
// Walks the frame header, tracks message state and pushes one result word
// per byte that yields a result.
// ============================================================================
module wsd_front #(
    parameter int MSG_LEN_BITS = wsd_pkg::MSG_LEN_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [7:0]              i_rx_byte,
    input  logic                    i_q_full,
    output logic                    o_push,
    output wsd_pkg::t_cmd           o_cmd,
    output logic [MSG_LEN_BITS-1:0] o_cnt
);

    typedef enum logic [5:0] {
        PH_HDR0    = 6'b000001,
        PH_HDR1    = 6'b000010,
        PH_EXT     = 6'b000100,
        PH_MASK    = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_CLOSED  = 6'b100000
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic                    r_fin, n_fin;
    logic [3:0]              r_op, n_op;
    logic                    r_masked, n_masked;
    logic [63:0]             r_left, n_left;
    logic [3:0]              r_hcnt, n_hcnt;
    logic [31:0]             r_key, n_key;
    logic [1:0]              r_mpos, n_mpos;
    logic [3:0]              r_msg_op, n_msg_op;
    logic [MSG_LEN_BITS-1:0] r_cnt, n_cnt;

    logic                    w_acc;
    logic                    w_hdr_done;
    logic                    w_last;
    logic                    w_msg_open;
    logic [7:0]              w_mask_byte;
    logic [6:0]              w_len7;
    logic [MSG_LEN_BITS-1:0] w_cnt_inc;

    assign o_stall    = i_q_full;
    assign w_acc      = i_valid && !i_q_full;
    assign w_len7     = i_rx_byte[6:0];
    assign w_last     = (r_left == 64'd1);
    assign w_cnt_inc  = (&r_cnt) ? r_cnt : r_cnt + MSG_LEN_BITS'(1);
    assign w_msg_open = (r_msg_op == wsd_pkg::OP_TEXT) || (r_msg_op == wsd_pkg::OP_BIN);

    always_comb begin
        unique case (r_mpos)
            2'd0:    w_mask_byte = r_key[31:24];
            2'd1:    w_mask_byte = r_key[23:16];
            2'd2:    w_mask_byte = r_key[15:8];
            default: w_mask_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_fin      = r_fin;
        n_op       = r_op;
        n_masked   = r_masked;
        n_left     = r_left;
        n_hcnt     = r_hcnt;
        n_key      = r_key;
        n_mpos     = r_mpos;
        n_msg_op   = r_msg_op;
        n_cnt      = r_cnt;
        w_hdr_done = 1'b0;
        o_push     = 1'b0;
        o_cmd      = '0;
        o_cnt      = '0;

        if (w_acc) begin
            unique case (r_phase)
                PH_HDR0: begin
                    n_fin   = i_rx_byte[7];
                    n_op    = i_rx_byte[3:0];
                    n_phase = PH_HDR1;
                end
                PH_HDR1: begin
                    n_masked = i_rx_byte[7];
                    n_key    = '0;
                    if (w_len7 == wsd_pkg::LEN_EXT16 || w_len7 == wsd_pkg::LEN_EXT64) begin
                        n_left  = '0;
                        n_hcnt  = (w_len7 == wsd_pkg::LEN_EXT16) ? 4'd2 : 4'd8;
                        n_phase = PH_EXT;
                    end else begin
                        n_left = {57'd0, w_len7};
                        if (i_rx_byte[7]) begin
                            n_hcnt  = 4'd4;
                            n_phase = PH_MASK;
                        end else begin
                            w_hdr_done = 1'b1;
                        end
                    end
                end
                PH_EXT: begin
                    n_left = {r_left[55:0], i_rx_byte};
                    n_hcnt = r_hcnt - 4'd1;
                    if (r_hcnt == 4'd1) begin
                        if (r_masked) begin
                            n_hcnt  = 4'd4;
                            n_phase = PH_MASK;
                        end else begin
                            w_hdr_done = 1'b1;
                        end
                    end
                end
                PH_MASK: begin
                    n_key  = {r_key[23:0], i_rx_byte};
                    n_hcnt = r_hcnt - 4'd1;
                    if (r_hcnt == 4'd1) begin
                        w_hdr_done = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    n_left    = r_left - 64'd1;
                    n_mpos    = r_mpos + 2'd1;
                    o_cmd.raw = i_rx_byte;
                    o_cmd.mask = r_masked ? w_mask_byte : 8'd0;
                    if (w_last) begin
                        n_phase = PH_HDR0;
                    end
                    priority if (r_op == wsd_pkg::OP_PING) begin
                        o_push         = 1'b1;
                        o_cmd.has_byte = 1'b1;
                        o_cmd.kind     = wsd_pkg::KIND_PING;
                        o_cmd.eom      = w_last;
                    end else if (r_op == wsd_pkg::OP_CLOSE) begin
                        // payload consumed silently; event pushed with the last byte
                        if (w_last) begin
                            o_push     = 1'b1;
                            o_cmd      = '0;
                            o_cmd.kind = wsd_pkg::KIND_CLOSE;
                            o_cmd.eom  = 1'b1;
                            n_phase    = PH_CLOSED;
                        end
                    end else if (r_op == wsd_pkg::OP_PONG) begin
                        o_push = 1'b0;
                    end else begin
                        n_cnt = w_cnt_inc;
                        if (w_msg_open) begin
                            o_push         = 1'b1;
                            o_cmd.has_byte = 1'b1;
                            o_cmd.kind     = (r_msg_op == wsd_pkg::OP_TEXT)
                                           ? wsd_pkg::KIND_TEXT : wsd_pkg::KIND_BIN;
                            o_cmd.eom      = w_last && r_fin;
                            o_cnt          = w_cnt_inc;
                        end
                        if (w_last && r_fin) begin
                            n_msg_op = wsd_pkg::OP_CONT;
                            n_cnt    = '0;
                        end
                    end
                end
                PH_CLOSED: begin
                    n_phase = PH_CLOSED;
                end
                default: begin
                    n_phase = PH_HDR0;
                end
            endcase

            if (w_hdr_done) begin
                n_mpos = 2'd0;
                // a new data or unknown opcode opens a message, dropping any open one
                if (r_op != wsd_pkg::OP_CONT && r_op != wsd_pkg::OP_CLOSE
                        && r_op != wsd_pkg::OP_PING && r_op != wsd_pkg::OP_PONG) begin
                    n_msg_op = r_op;
                    n_cnt    = '0;
                end
                if (n_left == 64'd0) begin
                    n_phase = PH_HDR0;
                    priority if (r_op == wsd_pkg::OP_CLOSE) begin
                        o_push     = 1'b1;
                        o_cmd.kind = wsd_pkg::KIND_CLOSE;
                        o_cmd.eom  = 1'b1;
                        n_phase    = PH_CLOSED;
                    end else if (r_op == wsd_pkg::OP_PING) begin
                        o_push     = 1'b1;
                        o_cmd.kind = wsd_pkg::KIND_PING;
                        o_cmd.eom  = 1'b1;
                    end else if (r_op == wsd_pkg::OP_PONG) begin
                        o_push = 1'b0;
                    end else if (r_fin) begin
                        // zero-length end marker
                        if (n_msg_op == wsd_pkg::OP_TEXT || n_msg_op == wsd_pkg::OP_BIN) begin
                            o_push     = 1'b1;
                            o_cmd.kind = (n_msg_op == wsd_pkg::OP_TEXT)
                                       ? wsd_pkg::KIND_TEXT : wsd_pkg::KIND_BIN;
                            o_cmd.eom  = 1'b1;
                            o_cnt      = n_cnt;
                        end
                        n_msg_op = wsd_pkg::OP_CONT;
                        n_cnt    = '0;
                    end
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_fin    <= 1'b0;
            r_op     <= wsd_pkg::OP_CONT;
            r_masked <= 1'b0;
            r_left   <= '0;
            r_hcnt   <= '0;
            r_key    <= '0;
            r_mpos   <= '0;
            r_msg_op <= wsd_pkg::OP_CONT;
            r_cnt    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_fin    <= n_fin;
            r_op     <= n_op;
            r_masked <= n_masked;
            r_left   <= n_left;
            r_hcnt   <= n_hcnt;
            r_key    <= n_key;
            r_mpos   <= n_mpos;
            r_msg_op <= n_msg_op;
            r_cnt    <= n_cnt;
        end
    end

endmodule

FILE: rtl/wsd_queue.sv
// ============================================================================
// wsd_queue: short result queue between parser and output stage
// Small circular buffer of result words with a full flag toward the parser.
// ============================================================================
module wsd_queue #(
    parameter int MSG_LEN_BITS = wsd_pkg::MSG_LEN_BITS_DEF,
    parameter int Q_DEPTH      = wsd_pkg::Q_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  wsd_pkg::t_cmd           i_cmd,
    input  logic [MSG_LEN_BITS-1:0] i_cnt,
    output logic                    o_full,
    input  logic                    i_pop,
    output logic                    o_nonempty,
    output wsd_pkg::t_cmd           o_cmd,
    output logic [MSG_LEN_BITS-1:0] o_cnt
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    wsd_pkg::t_cmd           r_cmd_mem [Q_DEPTH];
    logic [MSG_LEN_BITS-1:0] r_cnt_mem [Q_DEPTH];
    logic [PW-1:0]           r_wr, n_wr;
    logic [PW-1:0]           r_rd, n_rd;
    logic [CW-1:0]           r_fill, n_fill;

    assign o_full     = (r_fill == CW'(Q_DEPTH));
    assign o_nonempty = (r_fill != '0);
    assign o_cmd      = r_cmd_mem[r_rd];
    assign o_cnt      = r_cnt_mem[r_rd];

    always_comb begin
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_fill = r_fill;
        if (i_push) begin
            n_wr = (r_wr == PW'(Q_DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(Q_DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        unique case ({i_push, i_pop})
            2'b10:   n_fill = r_fill + CW'(1);
            2'b01:   n_fill = r_fill - CW'(1);
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_cmd_mem[r_wr] <= i_cmd;
            r_cnt_mem[r_wr] <= i_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

endmodule

FILE: rtl/wsd_back.sv
// ============================================================================
// wsd_back: unmasking and output register stage
// Applies the mask byte, saturates the length to 32 bits, holds the word
// until the consumer takes it.
// ============================================================================
module wsd_back #(
    parameter int MSG_LEN_BITS = wsd_pkg::MSG_LEN_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_nonempty,
    input  wsd_pkg::t_cmd           i_cmd,
    input  logic [MSG_LEN_BITS-1:0] i_cnt,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [7:0]              o_data_byte,
    output logic                    o_has_byte,
    output logic [1:0]              o_kind,
    output logic                    o_end_of_message,
    output logic [31:0]             o_message_length
);

    logic        r_valid, n_valid;
    logic [7:0]  r_data;
    logic        r_has;
    logic [1:0]  r_kind;
    logic        r_eom;
    logic [31:0] r_len;
    logic [31:0] w_len;

    generate
        if (MSG_LEN_BITS > 32) begin : g_sat
            assign w_len = (|i_cnt[MSG_LEN_BITS-1:32]) ? 32'hFFFF_FFFF : i_cnt[31:0];
        end else begin : g_ext
            assign w_len = 32'(i_cnt);
        end
    endgenerate

    assign o_pop   = i_q_nonempty && (!r_valid || !i_stall);
    assign n_valid = o_pop || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_cmd.has_byte ? (i_cmd.raw ^ i_cmd.mask) : 8'd0;
            r_has  <= i_cmd.has_byte;
            r_kind <= i_cmd.kind;
            r_eom  <= i_cmd.eom;
            r_len  <= w_len;
        end
    end

    assign o_valid          = r_valid;
    assign o_data_byte      = r_data;
    assign o_has_byte       = r_has;
    assign o_kind           = r_kind;
    assign o_end_of_message = r_eom;
    assign o_message_length = r_len;

endmodule

FILE: rtl/websocket_frame_deframer_core.sv
// Path: a result word is written into the queue when its byte is accepted, then
// moved into the output register, from which the consumer takes it.
// Throughput: one received byte per cycle while the result queue is not full.
// Bytes that yield no result (header, pong, close payload) are taken at that rate too.
// The input stalls only while the result queue (Q_DEPTH words) is full.
// Reset: synchronous, active low; parser returns to the first header byte,
// queue and output register empty. No clearing pass.
// ============================================================================
// websocket_frame_deframer_core: WebSocket receive-side frame parser
// Parses frame headers, unmasks payload bytes and tags them with the message
// kind; emits end-of-message markers, ping payloads and a close event.
// ============================================================================
module websocket_frame_deframer_core #(
    parameter int MSG_LEN_BITS = wsd_pkg::MSG_LEN_BITS_DEF,
    parameter int Q_DEPTH      = wsd_pkg::Q_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    // result words
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_data_byte,
    output logic        o_has_byte,
    output logic [1:0]  o_kind,
    output logic        o_end_of_message,
    output logic [31:0] o_message_length
);

    // parser -> queue
    logic                    w_push;
    wsd_pkg::t_cmd           w_push_cmd;
    logic [MSG_LEN_BITS-1:0] w_push_cnt;
    logic                    w_q_full;

    // queue -> output stage
    logic                    w_pop;
    logic                    w_q_nonempty;
    wsd_pkg::t_cmd           w_head_cmd;
    logic [MSG_LEN_BITS-1:0] w_head_cnt;

    // Front: header walk, message tracking, one word per result-bearing byte.
    // Unmasking is deferred; the word carries the raw byte and its mask byte.
    wsd_front #(
        .MSG_LEN_BITS (MSG_LEN_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (w_q_full),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd),
        .o_cnt     (w_push_cnt)
    );

    // Queue decouples the parser from a stalled consumer.
    wsd_queue #(
        .MSG_LEN_BITS (MSG_LEN_BITS),
        .Q_DEPTH      (Q_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_cmd      (w_push_cmd),
        .i_cnt      (w_push_cnt),
        .o_full     (w_q_full),
        .i_pop      (w_pop),
        .o_nonempty (w_q_nonempty),
        .o_cmd      (w_head_cmd),
        .o_cnt      (w_head_cnt)
    );

    // Back: unmask, saturate length, hold the word under stall.
    wsd_back #(
        .MSG_LEN_BITS (MSG_LEN_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_nonempty     (w_q_nonempty),
        .i_cmd            (w_head_cmd),
        .i_cnt            (w_head_cnt),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_data_byte      (o_data_byte),
        .o_has_byte       (o_has_byte),
        .o_kind           (o_kind),
        .o_end_of_message (o_end_of_message),
        .o_message_length (o_message_length)
    );

    // Queue never takes a word while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("result queue overflow");

    // A word without a payload byte carries a zero data byte
    a_empty_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_byte) |-> (o_data_byte == 8'd0))
        else $error("data byte set on a marker word");

    // Close event is a bare end marker with zero length
    a_close_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == wsd_pkg::KIND_CLOSE)
            |-> (!o_has_byte && o_end_of_message && o_message_length == 32'd0))
        else $error("malformed close event");

    // Ping words report no message length
    a_ping_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == wsd_pkg::KIND_PING) |-> (o_message_length == 32'd0))
        else $error("ping word carries a length");

endmodule
